// ===== hw/rtl/token_mutex_node_core_defines.svh =====
// assertion macros for the token mutex node
`ifndef TOKEN_MUTEX_NODE_CORE_DEFINES_SVH
`define TOKEN_MUTEX_NODE_CORE_DEFINES_SVH
`define TMN_ASSERT_IMP(lbl, clk, rstn, a, c) lbl: assert property (@(posedge clk) \
    disable iff (!rstn) (a) |-> (c)) else $error("assertion failed");
`define TMN_ASSERT_NXT(lbl, clk, rstn, a, c) lbl: assert property (@(posedge clk) \
    disable iff (!rstn) (a) |=> (c)) else $error("assertion failed");
`endif

// ===== hw/rtl/tmn_pkg.sv =====
// shared types and codes for the token mutex node
package tmn_pkg;
    localparam logic [2:0] MODE_LREQ = 3'd0;
    localparam logic [2:0] MODE_LREL = 3'd1;
    localparam logic [2:0] MODE_RREQ = 3'd2;
    localparam logic [2:0] MODE_THDR = 3'd3;
    localparam logic [2:0] MODE_TTBL = 3'd4;
    localparam logic [2:0] MODE_TQUE = 3'd5;
    localparam logic [2:0] KIND_REQ = 3'd0;
    localparam logic [2:0] KIND_HDR = 3'd1;
    localparam logic [2:0] KIND_TBL = 3'd2;
    localparam logic [2:0] KIND_QUE = 3'd3;
    localparam logic [2:0] KIND_GRANT = 3'd4;
    localparam logic CFG_OWN_ID = 1'b0;
    localparam logic CFG_NODE_COUNT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD, ST_LREQ, ST_GRANT, ST_SCAN_RD, ST_SCAN, ST_POP,
        ST_HDR, ST_TBL_RD, ST_TBL, ST_QUE, ST_RREQ, ST_TOK, ST_OUT
    } state_t;
endpackage

// ===== hw/rtl/token_mutex_node_core.sv =====
// top level of one token mutex node
//  channel | dir | handshake            | payload
//  in      | in  | in_valid / in_ready  | mode node seq_value queue_len last_word
//  out     | out | out_valid / out_ready| kind dest index value last
//  cfg     | in  | cfg_valid / cfg_ready| cfg_index cfg_data
// one item at a time: remote requests, token words, local requests (with a grant
// when the token is held) and releases (which, while the token is held, scan every
// active node and may ship the token as a header, the table words and the queue words);
// the table memories have one read port each
// reset clears control state and the valid bits of both tables
// out_ready low holds the sequencer on the pending result beat
module token_mutex_node_core #(
    parameter int MAX_NODES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  mode,
    input  logic [2:0]  node,
    input  logic [31:0] seq_value,
    input  logic [2:0]  queue_len,
    input  logic        last_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [2:0]  dest,
    output logic [2:0]  index,
    output logic [31:0] value,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data
);
    import tmn_pkg::*;
    `include "token_mutex_node_core_defines.svh"

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);

    // tables: request numbers and served numbers, one read port each
    logic [31:0] req_mem [MAX_NODES];
    logic [31:0] srv_mem [MAX_NODES];
    logic [MAX_NODES-1:0] req_vld_reg, srv_vld_reg;
    logic [AW-1:0] queue_reg [MAX_NODES];

    state_t state_reg, state_next;
    logic [2:0]  own_reg;
    logic [3:0]  ncnt_reg;
    logic [CW-1:0] wcnt_reg, wcnt_next;
    logic [CW-1:0] rx_reg;
    logic hold_reg, hold_next, insec_reg, insec_next, await_reg, await_next;
    logic [2:0]  mode_reg;
    logic [2:0]  node_reg;
    logic [31:0] seq_reg;
    logic [2:0]  qlen_reg;
    logic        lastw_reg;
    logic [CW-1:0] i_reg, i_next;
    logic [2:0]  dst_reg, dst_next;
    logic [AW-1:0] ra_req, ra_srv;
    logic [31:0] rq_raw, sv_raw, rq_d, sv_d;
    logic [AW-1:0] rq_a_reg, sv_a_reg;
    logic        we_req, we_srv;
    logic [AW-1:0] wa_req, wa_srv;
    logic [31:0] wd_req, wd_srv;
    logic        ob_v_reg, ob_v_next;
    logic [2:0]  ob_k_reg, ob_k_next, ob_d_reg, ob_d_next, ob_i_reg, ob_i_next;
    logic [31:0] ob_val_reg, ob_val_next;
    logic        ob_l_reg, ob_l_next;
    state_t      after_reg, after_next;
    logic [CW-1:0] n_act;
    logic [AW-1:0] me;
    logic        q_app, queued;
    logic [CW-1:0] qw_idx;
    logic        q_pop;
    logic        q_rx;

    assign me = AW'(own_reg);
    always_comb
    begin
        if (ncnt_reg > 4'(MAX_NODES > 15 ? 15 : MAX_NODES)
            && MAX_NODES <= 15)
            n_act = CW'(MAX_NODES);
        else if (ncnt_reg < 4'd2)
            n_act = CW'(2);
        else
            n_act = CW'(ncnt_reg);
    end

    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_ready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign out_valid = ob_v_reg;
    assign kind = ob_k_reg;
    assign dest = ob_d_reg;
    assign index = ob_i_reg;
    assign value = ob_val_reg;
    assign last = ob_l_reg;

    always_ff @(posedge clk)
    begin
        if (we_req) req_mem[wa_req] <= wd_req;
        if (we_srv) srv_mem[wa_srv] <= wd_srv;
        rq_raw <= req_mem[ra_req];
        sv_raw <= srv_mem[ra_srv];
        if (q_rx) queue_reg[rx_reg[AW-1:0]] <= AW'(node_reg);
        else if (q_pop)
        begin
            for (int k = 0; k < MAX_NODES - 1; k++)
                queue_reg[k] <= queue_reg[k+1];
        end
        else if (q_app) queue_reg[wcnt_reg[AW-1:0]] <= i_reg[AW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rq_a_reg <= '0;
            sv_a_reg <= '0;
        end
        else
        begin
            rq_a_reg <= ra_req;
            sv_a_reg <= ra_srv;
        end
    end
    assign rq_d = req_vld_reg[rq_a_reg] ? rq_raw : 32'd0;
    assign sv_d = srv_vld_reg[sv_a_reg] ? sv_raw : 32'd0;

    always_comb
    begin
        queued = 1'b0;
        for (int j = 0; j < MAX_NODES; j++)
            if (CW'(j) < wcnt_reg && queue_reg[j] == i_reg[AW-1:0]) queued = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            own_reg <= '0;
            ncnt_reg <= 4'd8;
            wcnt_reg <= '0;
            rx_reg <= '0;
            hold_reg <= 1'b1;
            insec_reg <= 1'b0;
            await_reg <= 1'b0;
            req_vld_reg <= '0;
            srv_vld_reg <= '0;
            i_reg <= '0;
            dst_reg <= '0;
            ob_v_reg <= 1'b0;
            after_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            wcnt_reg <= wcnt_next;
            if (cfg_valid && cfg_ready && cfg_index == CFG_OWN_ID)
                hold_reg <= (cfg_data[2:0] == 3'd0);
            else
                hold_reg <= hold_next;
            insec_reg <= insec_next;
            await_reg <= await_next;
            i_reg <= i_next;
            dst_reg <= dst_next;
            ob_v_reg <= ob_v_next;
            after_reg <= after_next;
            if (we_req) req_vld_reg[wa_req] <= 1'b1;
            if (we_srv) srv_vld_reg[wa_srv] <= 1'b1;
            if (state_reg == ST_TOK && mode_reg == MODE_THDR) rx_reg <= '0;
            else if (q_rx) rx_reg <= rx_reg + CW'(1);
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_OWN_ID: own_reg <= cfg_data[2:0];
                    CFG_NODE_COUNT: ncnt_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg <= mode;
            node_reg <= node;
            seq_reg <= seq_value;
            qlen_reg <= queue_len;
            lastw_reg <= last_word;
        end
        ob_k_reg <= ob_k_next;
        ob_d_reg <= ob_d_next;
        ob_i_reg <= ob_i_next;
        ob_val_reg <= ob_val_next;
        ob_l_reg <= ob_l_next;
    end

    always_comb
    begin
        state_next = state_reg;
        wcnt_next = wcnt_reg;
        hold_next = hold_reg;
        insec_next = insec_reg;
        await_next = await_reg;
        i_next = i_reg;
        dst_next = dst_reg;
        after_next = after_reg;
        ob_v_next = ob_v_reg && !out_ready;
        ob_k_next = ob_k_reg;
        ob_d_next = ob_d_reg;
        ob_i_next = ob_i_reg;
        ob_val_next = ob_val_reg;
        ob_l_next = ob_l_reg;
        ra_req = me;
        ra_srv = me;
        we_req = 1'b0;
        we_srv = 1'b0;
        wa_req = me;
        wa_srv = me;
        wd_req = rq_d + 32'd1;
        wd_srv = rq_d;
        q_app = 1'b0;
        q_pop = 1'b0;
        q_rx = 1'b0;
        qw_idx = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    state_next = ST_RD;
                    ra_req = (mode == MODE_RREQ) ? AW'(node) : me;
                    ra_srv = (mode == MODE_RREQ) ? AW'(node) : me;
                    ra_req = (mode == MODE_RREQ) ? ra_req : me;
                end
            end
            ST_RD:
            begin
                ra_req = (mode_reg == MODE_RREQ) ? AW'(node_reg) : me;
                ra_srv = ra_req;
                unique case (mode_reg) inside
                    MODE_LREQ:
                    begin
                        if (!ob_v_reg || out_ready)
                        begin
                            we_req = 1'b1;
                            wd_req = rq_d + 32'd1;
                            await_next = 1'b1;
                            ob_v_next = 1'b1;
                            ob_k_next = KIND_REQ;
                            ob_d_next = 3'd0;
                            ob_i_next = own_reg;
                            ob_val_next = rq_d + 32'd1;
                            ob_l_next = !hold_reg;
                            state_next = ST_OUT;
                            after_next = hold_reg ? ST_GRANT : ST_IDLE;
                        end
                    end
                    MODE_LREL:
                    begin
                        insec_next = 1'b0;
                        if (!hold_reg) state_next = ST_IDLE;
                        else
                        begin
                            we_srv = 1'b1;
                            wd_srv = rq_d;
                            i_next = '0;
                            state_next = ST_SCAN_RD;
                        end
                    end
                    MODE_RREQ:
                    begin
                        state_next = ST_IDLE;
                        if (node_reg != own_reg && CW'(node_reg) < n_act
                            && {1'b0, node_reg} < 4'(MAX_NODES > 8 ? 8 : MAX_NODES))
                        begin
                            we_req = seq_reg > rq_d;
                            wa_req = AW'(node_reg);
                            wd_req = seq_reg;
                            if (!await_reg && hold_reg && !insec_reg &&
                                (sv_d + 32'd1) == ((seq_reg > rq_d) ? seq_reg : rq_d))
                            begin
                                dst_next = node_reg;
                                state_next = ST_HDR;
                            end
                        end
                    end
                    MODE_THDR, MODE_TTBL, MODE_TQUE: state_next = ST_TOK;
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_TOK:
            begin
                state_next = ST_IDLE;
                case (mode_reg)
                    MODE_THDR:
                        wcnt_next = (CW'(qlen_reg) > CW'(MAX_NODES)) ? CW'(MAX_NODES)
                                                                     : CW'(qlen_reg);
                    MODE_TTBL:
                    begin
                        we_srv = 1'b1;
                        wa_srv = AW'(node_reg);
                        wd_srv = seq_reg;
                    end
                    default:
                        q_rx = rx_reg < CW'(MAX_NODES);
                endcase
                if (lastw_reg)
                begin
                    hold_next = 1'b1;
                    if (await_reg) state_next = ST_GRANT;
                end
            end
            ST_GRANT:
            begin
                ra_req = me;
                if (!ob_v_reg || out_ready) state_next = ST_RREQ;
            end
            ST_RREQ:
            begin
                // grant beat using freshly read own number
                insec_next = 1'b1;
                await_next = 1'b0;
                ob_v_next = 1'b1;
                ob_k_next = KIND_GRANT;
                ob_d_next = own_reg;
                ob_i_next = own_reg;
                ob_val_next = rq_d;
                ob_l_next = 1'b1;
                state_next = ST_OUT;
                after_next = ST_IDLE;
            end
            ST_SCAN_RD:
            begin
                ra_req = i_reg[AW-1:0];
                ra_srv = i_reg[AW-1:0];
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (rq_d == sv_d + 32'd1 && !queued && wcnt_reg < CW'(MAX_NODES))
                begin
                    q_app = 1'b1;
                    wcnt_next = wcnt_reg + CW'(1);
                end
                if (i_reg + CW'(1) >= n_act) state_next = ST_POP;
                else
                begin
                    i_next = i_reg + CW'(1);
                    state_next = ST_SCAN_RD;
                end
            end
            ST_POP:
            begin
                if (wcnt_reg == '0) state_next = ST_IDLE;
                else
                begin
                    dst_next = 3'(queue_reg[0]);
                    q_pop = 1'b1;
                    wcnt_next = wcnt_reg - CW'(1);
                    state_next = ST_HDR;
                end
            end
            ST_HDR:
            begin
                if (!ob_v_reg || out_ready)
                begin
                    ob_v_next = 1'b1;
                    ob_k_next = KIND_HDR;
                    ob_d_next = dst_reg;
                    ob_i_next = 3'd0;
                    ob_val_next = 32'(wcnt_reg);
                    ob_l_next = 1'b0;
                    hold_next = 1'b0;
                    i_next = '0;
                    state_next = ST_TBL_RD;
                end
            end
            ST_TBL_RD:
            begin
                ra_srv = i_reg[AW-1:0];
                state_next = ST_TBL;
            end
            ST_TBL:
            begin
                ra_srv = i_reg[AW-1:0];
                if (!ob_v_reg || out_ready)
                begin
                    ob_v_next = 1'b1;
                    ob_k_next = KIND_TBL;
                    ob_d_next = dst_reg;
                    ob_i_next = 3'(i_reg);
                    ob_val_next = sv_d;
                    ob_l_next = (i_reg + CW'(1) >= n_act) && wcnt_reg == '0;
                    i_next = i_reg + CW'(1);
                    if (i_reg + CW'(1) >= n_act)
                    begin
                        i_next = '0;
                        state_next = (wcnt_reg == '0) ? ST_IDLE : ST_QUE;
                    end
                    else state_next = ST_TBL_RD;
                end
            end
            ST_QUE:
            begin
                qw_idx = i_reg;
                if (!ob_v_reg || out_ready)
                begin
                    ob_v_next = 1'b1;
                    ob_k_next = KIND_QUE;
                    ob_d_next = dst_reg;
                    ob_i_next = 3'(queue_reg[qw_idx[AW-1:0]]);
                    ob_val_next = 32'd0;
                    ob_l_next = (i_reg + CW'(1) >= wcnt_reg);
                    i_next = i_reg + CW'(1);
                    if (i_reg + CW'(1) >= wcnt_reg) state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (!ob_v_reg || out_ready) state_next = after_reg;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `TMN_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, $stable(value) && $stable(kind))
    `TMN_ASSERT_NXT(a_ob_stall, clk, rst_n, out_valid && !out_ready, out_valid)
    `TMN_ASSERT_IMP(a_wcnt_max, clk, rst_n, 1'b1, wcnt_reg <= CW'(MAX_NODES))
    `TMN_ASSERT_IMP(a_no_in_busy, clk, rst_n, state_reg != ST_IDLE, !in_ready)
endmodule

// ===== verif/token_mutex_node_core_tb.sv =====
// self-checking testbench for the token mutex node core
module token_mutex_node_core_tb;
    import tmn_pkg::*;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  dest;
        logic [2:0]  index;
        logic [31:0] value;
        logic        last;
    } beat_t;

    class token_scoreboard;
        logic [2:0]  own;
        logic [3:0]  count;
        logic [31:0] req_no [8];
        logic [31:0] served [8];
        logic [2:0]  waiters [8];
        int          n_wait;
        bit          holding;
        bit          in_cs;
        bit          waiting;
        int          rx_pos;
        beat_t       pending [$];
        int          errors;
        int          checked;

        function void clear();
            own = 3'd0;
            count = 4'd8;
            foreach (req_no[i])
            begin
                req_no[i] = 32'd0;
                served[i] = 32'd0;
                waiters[i] = 3'd0;
            end
            n_wait = 0;
            holding = 1;
            in_cs = 0;
            waiting = 0;
            rx_pos = 0;
            pending.delete();
        endfunction

        function void set_reg(logic idx, logic [3:0] data);
            if (idx == CFG_OWN_ID)
            begin
                own = data[2:0];
                holding = (data[2:0] == 3'd0);
            end
            else
            begin
                count = data;
            end
        endfunction

        function int nodes();
            if (count > 4'd8) return 8;
            if (count < 4'd2) return 2;
            return int'(count);
        endfunction

        function void push(logic [2:0] k, logic [2:0] d, logic [2:0] i, logic [31:0] v);
            beat_t b;
            b.kind = k;
            b.dest = d;
            b.index = i;
            b.value = v;
            b.last = 0;
            pending = {pending, b};
        endfunction

        function void send_token(logic [2:0] d);
            push(KIND_HDR, d, 3'd0, 32'(n_wait));
            for (int i = 0; i < nodes(); i++)
                push(KIND_TBL, d, i[2:0], served[i]);
            for (int i = 0; i < n_wait && i < 8; i++)
                push(KIND_QUE, d, waiters[i], 32'd0);
            holding = 0;
        endfunction

        function void grant();
            in_cs = 1;
            waiting = 0;
            push(KIND_GRANT, own, own, req_no[own]);
        endfunction

        function void note_input(logic [2:0] md, logic [2:0] nd, logic [31:0] sq,
                                 logic [2:0] ql, logic lw);
            int base;
            bit queued;
            logic [2:0] head;
            base = pending.size();
            case (md) inside
                MODE_LREQ:
                begin
                    req_no[own] = req_no[own] + 32'd1;
                    waiting = 1;
                    push(KIND_REQ, 3'd0, own, req_no[own]);
                    if (holding) grant();
                end
                MODE_LREL:
                begin
                    in_cs = 0;
                    if (holding)
                    begin
                        served[own] = req_no[own];
                        for (int i = 0; i < nodes(); i++)
                        begin
                            if (req_no[i] != served[i] + 32'd1) continue;
                            queued = 0;
                            for (int j = 0; j < n_wait && j < 8; j++)
                                if (waiters[j] == i) queued = 1;
                            if (!queued && n_wait < 8)
                            begin
                                waiters[n_wait] = i[2:0];
                                n_wait++;
                            end
                        end
                        if (n_wait > 0)
                        begin
                            head = waiters[0];
                            for (int j = 0; j < 7; j++) waiters[j] = waiters[j + 1];
                            n_wait--;
                            send_token(head);
                        end
                    end
                end
                MODE_RREQ:
                begin
                    if (nd != own && nd < nodes())
                    begin
                        if (sq > req_no[nd]) req_no[nd] = sq;
                        if (!waiting && holding && !in_cs && served[nd] + 32'd1 == req_no[nd])
                            send_token(nd);
                    end
                end
                MODE_THDR, MODE_TTBL, MODE_TQUE:
                begin
                    if (md == MODE_THDR)
                    begin
                        n_wait = int'(ql);
                        rx_pos = 0;
                    end
                    else if (md == MODE_TTBL)
                    begin
                        served[nd] = sq;
                    end
                    else if (rx_pos < 8)
                    begin
                        waiters[rx_pos] = nd;
                        rx_pos++;
                    end
                    if (lw)
                    begin
                        holding = 1;
                        if (waiting) grant();
                    end
                end
                default: ;
            endcase
            if (pending.size() > base) pending[pending.size() - 1].last = 1;
        endfunction

        function void check_beat(beat_t got);
            beat_t exp;
            checked++;
            if (pending.size() == 0)
            begin
                $error("unexpected beat kind=%0d", got.kind);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.kind !== exp.kind)
            begin
                $error("kind: expected %0d actual %0d", exp.kind, got.kind); errors++;
            end
            if (got.dest !== exp.dest)
            begin
                $error("dest: expected %0d actual %0d", exp.dest, got.dest); errors++;
            end
            if (got.index !== exp.index)
            begin
                $error("index: expected %0d actual %0d", exp.index, got.index); errors++;
            end
            if (got.value !== exp.value)
            begin
                $error("value: expected %0h actual %0h", exp.value, got.value); errors++;
            end
            if (got.last !== exp.last)
            begin
                $error("last: expected %0d actual %0d", exp.last, got.last); errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  mode;
    logic [2:0]  node;
    logic [31:0] seq_value;
    logic [2:0]  queue_len;
    logic        last_word;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  kind;
    logic [2:0]  dest;
    logic [2:0]  index;
    logic [31:0] value;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [3:0]  cfg_data;

    token_scoreboard sb;
    int items_sent;
    bit stall_enable;
    int out_gap;

    token_mutex_node_core uut (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result side: each beat draws its idle cycles before the next one
    initial
    begin
        out_ready = 1'b1;
        forever
        begin
            do @(posedge clk); while (!(rst_n && out_valid && out_ready));
            sb.check_beat(beat_t'({kind, dest, index, value, last}));
            out_gap = stall_enable ? $urandom_range(0, 16) : 0;
            if (out_gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (out_gap) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_item(logic [2:0] md, logic [2:0] nd, logic [31:0] sq,
                             logic [2:0] ql, logic lw);
        int gap;
        gap = stall_enable ? $urandom_range(0, 16) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= md;
        node <= nd;
        seq_value <= sq;
        queue_len <= ql;
        last_word <= lw;
        do @(posedge clk); while (!in_ready);
        sb.note_input(md, nd, sq, ql, lw);
        items_sent++;
    endtask

    task automatic write_reg(logic idx, logic [3:0] data);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, data);
        cfg_valid <= 1'b0;
    endtask

    // whole token with a valid queue; words drawn from the current setting
    task automatic send_token_in(int qn);
        int n;
        n = sb.nodes();
        send_item(MODE_THDR, 3'($urandom), $urandom, qn[2:0], 1'b0);
        for (int i = 0; i < n; i++)
            send_item(MODE_TTBL, i[2:0], $urandom_range(0, 6), 3'($urandom),
                      (qn == 0 && i == n - 1));
        for (int i = 0; i < qn; i++)
            send_item(MODE_TQUE, 3'($urandom_range(0, n - 1)), $urandom, 3'($urandom),
                      i == qn - 1);
    endtask

    task automatic random_phase(int count);
        int r;
        for (int t = 0; t < count; t++)
        begin
            r = $urandom_range(0, 99);
            if (r < 25)
                send_item(MODE_LREQ, 3'($urandom), $urandom, 3'($urandom), 1'($urandom));
            else if (r < 45)
                send_item(MODE_LREL, 3'($urandom), $urandom, 3'($urandom), 1'($urandom));
            else if (r < 75)
                send_item(MODE_RREQ, 3'($urandom_range(0, 7)),
                          ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 8),
                          3'($urandom), 1'($urandom));
            else if (r < 88) send_token_in(int'($urandom_range(0, 7)));
            else if (r < 94)
                send_item(MODE_TTBL, 3'($urandom), $urandom, 3'($urandom), 1'($urandom));
            else if (r < 97)
                send_item(MODE_THDR, 3'($urandom), $urandom, 3'd0, 1'($urandom));
            else
                send_item(3'($urandom_range(6, 7)), 3'($urandom), $urandom, 3'($urandom),
                          1'($urandom));
        end
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = MODE_LREQ;
        node = 3'd0;
        seq_value = 32'd0;
        queue_len = 3'd0;
        last_word = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_OWN_ID;
        cfg_data = 4'd0;
        items_sent = 0;
        stall_enable = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: node zero holds the token
        send_item(MODE_LREQ, 3'd0, 32'd0, 3'd0, 1'b0);
        send_item(MODE_LREQ, 3'd0, 32'd0, 3'd0, 1'b0);
        send_item(MODE_LREL, 3'd0, 32'd0, 3'd0, 1'b0);
        send_item(MODE_RREQ, 3'd0, 32'd5, 3'd0, 1'b0);
        send_item(MODE_RREQ, 3'd7, 32'hFFFF_FFFF, 3'd7, 1'b1);
        send_item(MODE_RREQ, 3'd3, 32'd1, 3'd0, 1'b0);
        send_item(MODE_LREL, 3'd0, 32'd0, 3'd0, 1'b0);
        send_item(MODE_LREQ, 3'd0, 32'd0, 3'd0, 1'b0);
        send_item(3'd6, 3'd7, 32'hFFFF_FFFF, 3'd7, 1'b1);
        send_item(3'd7, 3'd0, 32'd0, 3'd0, 1'b0);
        send_item(MODE_TTBL, 3'd7, 32'hFFFF_FFFF, 3'd7, 1'b0);
        send_token_in(7);
        send_item(MODE_LREL, 3'd0, 32'd0, 3'd0, 1'b0);

        stall_enable = 1;
        write_reg(CFG_NODE_COUNT, 4'd0);
        write_reg(CFG_OWN_ID, 4'd7);
        random_phase(30);
        write_reg(CFG_NODE_COUNT, 4'd15);
        write_reg(CFG_OWN_ID, 4'd0);
        random_phase(35);
        write_reg(CFG_NODE_COUNT, 4'd2);
        write_reg(CFG_OWN_ID, 4'd1);
        random_phase(25);
        write_reg(CFG_NODE_COUNT, 4'd5);
        write_reg(CFG_OWN_ID, 4'd2);
        stall_enable = 0;
        random_phase(10);
        stall_enable = 1;
        random_phase(15);
        in_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        $display("ran %0d input items, checked %0d result beats", items_sent, sb.checked);
        $display("covered four own_id / node_count settings incl. saturated counts");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("FAILURE");
        $finish;
    end
endmodule
